>>> hdl/ird_pkg.sv
// Shared types and constants for the input-restricted deque.
// Used by ird_cell and input_restricted_deque_unit; depends on nothing.
`default_nettype none

package ird_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int LIST_CAP = 16;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        KIND_INSERT    = 2'd0,
        KIND_DEL_FRONT = 2'd1,
        KIND_DEL_REAR  = 2'd2,
        KIND_LIST      = 2'd3
    } kind_t;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REMOVED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_LISTED   = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_NEXT  = 2'd2,
        CELL_FRONT = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> hdl/ird_cell.sv
// One storage cell of the deque chain: holds a word, loads new data,
// takes its upper neighbor's word, or takes the front word when rotating.
// Depends on ird_pkg.
`default_nettype none

module ird_cell (
    input  wire logic                       clk,
    input  wire ird_pkg::cell_ctl_t         ctl,
    input  wire logic [ird_pkg::DATA_W-1:0] load_data,
    input  wire logic [ird_pkg::DATA_W-1:0] next_data,
    input  wire logic [ird_pkg::DATA_W-1:0] front_data,
    output logic      [ird_pkg::DATA_W-1:0] value
);

    logic [ird_pkg::DATA_W-1:0] value_reg;
    logic [ird_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        unique case (ctl.mode)
            ird_pkg::CELL_HOLD:  value_next = value_reg;
            ird_pkg::CELL_LOAD:  value_next = load_data;
            ird_pkg::CELL_NEXT:  value_next = next_data;
            ird_pkg::CELL_FRONT: value_next = front_data;
            default:             value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

>>> hdl/input_restricted_deque_unit.sv
// Top level of the input-restricted deque: control and the row of cells.
// Depends on ird_pkg and ird_cell.
//
// Usage:
// The slave channel takes one request per transaction: tuser holds the
// operation (insert rear, delete front, delete rear, list) and tdata the
// value to insert. The master channel returns results: tuser is the status,
// tdata the removed or listed value (zero otherwise), tlast marks the final
// result of a request.
// The contents are kept packed in a row of cells with the front element in
// cell 0. Insert and both deletes give one result, which sits in the output
// register in the cycle after acceptance. A list request enters the list
// state, then rotates the row one cell per cycle while the output register
// can take a result, emitting cell 0 each time, so it gives one result per
// stored element. The full rotation restores the original order. No request
// is accepted while a list is in progress. When the receiver stalls, the
// output register holds its result and the block stops advancing until it
// is taken.
// Reset empties the deque and clears the output valid; cell contents are not
// cleared.
`default_nettype none

module input_restricted_deque_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] data_in
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] data_out
    output logic      [2:0]  m_axis_tuser,   // [2:0] status
    output logic             m_axis_tlast
);

    localparam int IW = ird_pkg::IDX_W;
    localparam int DW = ird_pkg::DATA_W;

    ird_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic            empty_reg, empty_next;
    logic [IW-1:0]   lst_cnt_reg, lst_cnt_next;

    logic            out_valid_reg;
    logic [2:0]      out_status_reg;
    logic [DW-1:0]   out_data_reg;
    logic            out_last_reg;

    logic            emit;
    logic [2:0]      emit_status;
    logic [DW-1:0]   emit_data;
    logic            emit_last;

    logic            adv;
    logic            in_acc;
    ird_pkg::kind_t  in_kind;
    logic [IW-1:0]   rear_off;

    ird_pkg::cell_ctl_t cell_ctl [ird_pkg::DEPTH];
    logic [DW-1:0]      cell_val [ird_pkg::DEPTH];

    // The output register can take a new result this cycle.
    assign adv      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ird_pkg::S_IDLE) && adv;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_kind  = ird_pkg::kind_t'(s_axis_tuser);
    // Cell index of the rear element.
    assign rear_off = tail_reg - head_reg;

    for (genvar i = 0; i < ird_pkg::DEPTH; i++)
    begin : g_cell
        logic [DW-1:0] next_data;
        if (i < ird_pkg::DEPTH - 1)
        begin : g_mid
            assign next_data = cell_val[i+1];
        end
        else
        begin : g_end
            assign next_data = '0;
        end

        ird_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .load_data  (s_axis_tdata),
            .next_data  (next_data),
            .front_data (cell_val[0]),
            .value      (cell_val[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        empty_next   = empty_reg;
        lst_cnt_next = lst_cnt_reg;
        emit         = 1'b0;
        emit_status  = ird_pkg::ST_EMPTY;
        emit_data    = '0;
        emit_last    = 1'b1;
        for (int i = 0; i < ird_pkg::DEPTH; i++)
        begin
            cell_ctl[i].mode = ird_pkg::CELL_HOLD;
        end

        unique case (state_reg)
            ird_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    emit = 1'b1;
                    unique case (in_kind)
                        ird_pkg::KIND_INSERT:
                        begin
                            if (empty_reg)
                            begin
                                cell_ctl[0].mode = ird_pkg::CELL_LOAD;
                                head_next   = '0;
                                tail_next   = '0;
                                empty_next  = 1'b0;
                                emit_status = ird_pkg::ST_INSERTED;
                            end
                            else if (tail_reg == IW'(ird_pkg::DEPTH - 1))
                            begin
                                emit_status = ird_pkg::ST_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < ird_pkg::DEPTH; i++)
                                begin
                                    if (IW'(i) == rear_off + 1'b1)
                                    begin
                                        cell_ctl[i].mode = ird_pkg::CELL_LOAD;
                                    end
                                end
                                tail_next   = tail_reg + 1'b1;
                                emit_status = ird_pkg::ST_INSERTED;
                            end
                        end
                        ird_pkg::KIND_DEL_FRONT:
                        begin
                            if (!empty_reg)
                            begin
                                for (int i = 0; i < ird_pkg::DEPTH; i++)
                                begin
                                    cell_ctl[i].mode = ird_pkg::CELL_NEXT;
                                end
                                emit_status = ird_pkg::ST_REMOVED;
                                emit_data   = cell_val[0];
                                if (rear_off == '0)
                                begin
                                    empty_next = 1'b1;
                                    head_next  = '0;
                                    tail_next  = '0;
                                end
                                else
                                begin
                                    head_next = head_reg + 1'b1;
                                end
                            end
                        end
                        ird_pkg::KIND_DEL_REAR:
                        begin
                            if (!empty_reg)
                            begin
                                emit_status = ird_pkg::ST_REMOVED;
                                emit_data   = cell_val[rear_off];
                                if (rear_off == '0)
                                begin
                                    empty_next = 1'b1;
                                    head_next  = '0;
                                    tail_next  = '0;
                                end
                                else
                                begin
                                    tail_next = tail_reg - 1'b1;
                                end
                            end
                        end
                        ird_pkg::KIND_LIST:
                        begin
                            if (!empty_reg)
                            begin
                                emit         = 1'b0;
                                lst_cnt_next = '0;
                                state_next   = ird_pkg::S_LIST;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            ird_pkg::S_LIST:
            begin
                if (adv)
                begin
                    // Rotate the occupied cells so the next element reaches cell 0.
                    for (int i = 0; i < ird_pkg::DEPTH; i++)
                    begin
                        if (IW'(i) < rear_off)
                        begin
                            cell_ctl[i].mode = ird_pkg::CELL_NEXT;
                        end
                        else if (IW'(i) == rear_off)
                        begin
                            cell_ctl[i].mode = ird_pkg::CELL_FRONT;
                        end
                    end
                    if (32'(lst_cnt_reg) < 32'(ird_pkg::LIST_CAP))
                    begin
                        emit        = 1'b1;
                        emit_status = ird_pkg::ST_LISTED;
                        emit_data   = cell_val[0];
                        emit_last   = (lst_cnt_reg == rear_off) ||
                                      (32'(lst_cnt_reg) == 32'(ird_pkg::LIST_CAP - 1));
                    end
                    if (lst_cnt_reg == rear_off)
                    begin
                        state_next = ird_pkg::S_IDLE;
                    end
                    else
                    begin
                        lst_cnt_next = lst_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ird_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ird_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            lst_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            empty_reg   <= empty_next;
            lst_cnt_reg <= lst_cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_data_reg   <= emit_data;
            out_last_reg   <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty deque with nonzero pointers");

    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (tail_reg >= head_reg))
        else $error("rear pointer below front pointer");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ird_pkg::S_LIST) |-> !empty_reg && !s_axis_tready)
        else $error("listing an empty deque or accepting during a list");

    a_list_state_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ird_pkg::S_LIST) |=> $stable(head_reg) && $stable(tail_reg))
        else $error("pointers changed during a list");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while the output register was stalled");
`endif

endmodule

`default_nettype wire
